FILE: sv/tbp_pkg.sv
// tbp_pkg: shared types and constants of the tensor border padding block.
// Field widths, register codes, reset values and pad mode codes.
// No dependencies.
package tbp_pkg;

   localparam int COL_W      = 8;
   localparam int ROW_W      = 8;
   localparam int CHAN_W     = 4;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int SRC_W_W  = 7;
   localparam int SRC_H_W  = 7;
   localparam int SRC_C_W  = 3;
   localparam int PAD_T_W  = 6;
   localparam int PAD_L_W  = 6;
   localparam int PAD_F_W  = 2;
   localparam int MODE_W   = 2;

   // signed working width of the axis arithmetic; holds sizes up to 1024
   localparam int AXIS_W = 12;

   localparam logic [SRC_W_W-1:0] SRC_W_RST = 7'd64;
   localparam logic [SRC_H_W-1:0] SRC_H_RST = 7'd64;
   localparam logic [SRC_C_W-1:0] SRC_C_RST = 3'd4;

   typedef enum logic [MODE_W-1:0] {
      PAD_CONST     = 2'd0,
      PAD_REPLICATE = 2'd1,
      PAD_REFLECT   = 2'd2,
      PAD_UNUSED    = 2'd3
   } pad_mode_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH    = 3'd0,
      CSR_SRC_HEIGHT   = 3'd1,
      CSR_SRC_CHANNELS = 3'd2,
      CSR_PAD_TOP      = 3'd3,
      CSR_PAD_LEFT     = 3'd4,
      CSR_PAD_FRONT    = 3'd5,
      CSR_PAD_MODE     = 3'd6,
      CSR_FILL_WORD    = 3'd7
   } csr_index_type;

endpackage

FILE: sv/tbp_axis_map.sv
// tbp_axis_map: maps one coordinate axis to a source index.
// Write: range check against the size. Read: constant, replicate or reflect.
// Depends on tbp_pkg.
module tbp_axis_map #(
   parameter int MAX_SIZE = 64,
   parameter int POS_W    = 8,
   parameter int PAD_W    = 6,
   parameter int SZ_W     = 7,
   parameter int IDX_W    = 6
) (
   input  logic                  is_read,
   input  logic [POS_W-1:0]      pos,
   input  logic [PAD_W-1:0]      pad,
   input  logic [SZ_W-1:0]       size_reg,
   input  tbp_pkg::pad_mode_type mode,
   output logic [IDX_W-1:0]      idx,
   output logic                  ok
);

   localparam int AW = tbp_pkg::AXIS_W;

   logic signed [AW-1:0] pos_s;
   logic signed [AW-1:0] pad_s;
   logic signed [AW-1:0] szr_s;
   logic signed [AW-1:0] size_s;
   logic signed [AW-1:0] last_s;
   logic signed [AW-1:0] p_s;
   logic signed [AW-1:0] m_s;
   logic signed [AW-1:0] far_s;

   always_comb begin
      pos_s = $signed({{(AW-POS_W){1'b0}}, pos});
      pad_s = $signed({{(AW-PAD_W){1'b0}}, pad});
      szr_s = $signed({{(AW-SZ_W){1'b0}}, size_reg});
      if (size_reg == '0) begin
         size_s = AW'(1);
      end else if (szr_s > AW'(MAX_SIZE)) begin
         size_s = AW'(MAX_SIZE);
      end else begin
         size_s = szr_s;
      end
      last_s = size_s - AW'(1);
      p_s    = pos_s - pad_s;
      far_s  = (last_s <<< 1) - p_s;
      m_s    = p_s;
      ok     = 1'b1;
      if (!is_read) begin
         m_s = pos_s;
         ok  = (pos_s < size_s);
      end else begin
         case (mode)
            tbp_pkg::PAD_REPLICATE: begin
               if (p_s < 0) begin
                  m_s = '0;
               end else if (p_s > last_s) begin
                  m_s = last_s;
               end
            end
            tbp_pkg::PAD_REFLECT: begin
               if (p_s < 0) begin
                  m_s = (-p_s > last_s) ? last_s : -p_s;
               end else if (p_s > last_s) begin
                  m_s = (far_s < 0) ? '0 : far_s;
               end
            end
            default: begin
               ok = (p_s >= 0) && (p_s < size_s);
            end
         endcase
      end
      idx = m_s[IDX_W-1:0];
   end

endmodule

FILE: sv/tbp_elem_mem.sv
// tbp_elem_mem: single-port element store, registered read.
// Contents undefined until written.
// No dependencies.
module tbp_elem_mem #(
   parameter int DEPTH = 16384,
   parameter int ADDR_W = 14,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/tensor_border_padding_top.sv
// tensor_border_padding_top: padded tensor store, top level.
// Uses tbp_pkg, tbp_axis_map and tbp_elem_mem.
//
// A transaction is taken when start is high and busy low; busy stays high for
// the cycle after, so no new one is taken until then. Each passes a request
// register, then one access to the single-port element memory. A read returns
// one result through the request register and then the response register,
// shown for exactly one cycle with rsp_valid; the receiver cannot stall it.
// Writes return nothing, and writes outside the configured sizes are dropped.
// The memory needs no clearing after reset; reading an element never written
// gives arbitrary data. Change csr registers only while the block is idle.
module tensor_border_padding_top #(
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_CHANNELS = 4,
   parameter int ELEM_BITS    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [tbp_pkg::COL_W-1:0]        req_col,
   input  logic [tbp_pkg::ROW_W-1:0]        req_row,
   input  logic [tbp_pkg::CHAN_W-1:0]       req_chan,
   input  logic [tbp_pkg::WORD_W-1:0]       req_wdata,
   output logic                             rsp_valid,
   output logic [tbp_pkg::WORD_W-1:0]       rsp_rdata,
   output logic                             rsp_from_fill,
   input  logic                             csr_we,
   input  logic [tbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int X_W    = $clog2(MAX_WIDTH);
   localparam int Y_W    = $clog2(MAX_HEIGHT);
   localparam int Z_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int PLANE  = MAX_WIDTH * MAX_HEIGHT;

   // configuration
   logic [tbp_pkg::SRC_W_W-1:0] src_w_ff, src_w_in;
   logic [tbp_pkg::SRC_H_W-1:0] src_h_ff, src_h_in;
   logic [tbp_pkg::SRC_C_W-1:0] src_c_ff, src_c_in;
   logic [tbp_pkg::PAD_T_W-1:0] pad_t_ff, pad_t_in;
   logic [tbp_pkg::PAD_L_W-1:0] pad_l_ff, pad_l_in;
   logic [tbp_pkg::PAD_F_W-1:0] pad_f_ff, pad_f_in;
   tbp_pkg::pad_mode_type       mode_ff,  mode_in;
   logic [ELEM_BITS-1:0]        fill_ff,  fill_in;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      src_c_in = src_c_ff;
      pad_t_in = pad_t_ff;
      pad_l_in = pad_l_ff;
      pad_f_in = pad_f_ff;
      mode_in  = mode_ff;
      fill_in  = fill_ff;
      if (csr_we) begin
         unique case (tbp_pkg::csr_index_type'(csr_index))
            tbp_pkg::CSR_SRC_WIDTH:    src_w_in = csr_wdata[tbp_pkg::SRC_W_W-1:0];
            tbp_pkg::CSR_SRC_HEIGHT:   src_h_in = csr_wdata[tbp_pkg::SRC_H_W-1:0];
            tbp_pkg::CSR_SRC_CHANNELS: src_c_in = csr_wdata[tbp_pkg::SRC_C_W-1:0];
            tbp_pkg::CSR_PAD_TOP:      pad_t_in = csr_wdata[tbp_pkg::PAD_T_W-1:0];
            tbp_pkg::CSR_PAD_LEFT:     pad_l_in = csr_wdata[tbp_pkg::PAD_L_W-1:0];
            tbp_pkg::CSR_PAD_FRONT:    pad_f_in = csr_wdata[tbp_pkg::PAD_F_W-1:0];
            tbp_pkg::CSR_PAD_MODE:
               mode_in = tbp_pkg::pad_mode_type'(csr_wdata[tbp_pkg::MODE_W-1:0]);
            tbp_pkg::CSR_FILL_WORD:    fill_in = csr_wdata[ELEM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= tbp_pkg::SRC_W_RST;
         src_h_ff <= tbp_pkg::SRC_H_RST;
         src_c_ff <= tbp_pkg::SRC_C_RST;
         pad_t_ff <= '0;
         pad_l_ff <= '0;
         pad_f_ff <= '0;
         mode_ff  <= tbp_pkg::PAD_CONST;
         fill_ff  <= '0;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         src_c_ff <= src_c_in;
         pad_t_ff <= pad_t_in;
         pad_l_ff <= pad_l_in;
         pad_f_ff <= pad_f_in;
         mode_ff  <= mode_in;
         fill_ff  <= fill_in;
      end
   end

   // request register
   logic                         accept;
   logic                         a_valid_ff, a_valid_in;
   logic                         a_op_ff;
   logic [tbp_pkg::COL_W-1:0]    a_col_ff;
   logic [tbp_pkg::ROW_W-1:0]    a_row_ff;
   logic [tbp_pkg::CHAN_W-1:0]   a_chan_ff;
   logic [ELEM_BITS-1:0]         a_wdata_ff;

   assign accept     = start && !a_valid_ff;
   assign a_valid_in = accept;
   assign busy       = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_op_ff    <= req_operation;
         a_col_ff   <= req_col;
         a_row_ff   <= req_row;
         a_chan_ff  <= req_chan;
         a_wdata_ff <= req_wdata[ELEM_BITS-1:0];
      end
   end

   // coordinate mapping
   logic             is_read;
   logic [X_W-1:0]   x_idx;
   logic [Y_W-1:0]   y_idx;
   logic [Z_W-1:0]   z_idx;
   logic             x_ok, y_ok, z_ok, all_ok;
   logic [ADDR_W-1:0] addr;

   assign is_read = (tbp_pkg::op_type'(a_op_ff) == tbp_pkg::OP_READ);

   tbp_axis_map #(
      .MAX_SIZE (MAX_WIDTH),
      .POS_W    (tbp_pkg::COL_W),
      .PAD_W    (tbp_pkg::PAD_L_W),
      .SZ_W     (tbp_pkg::SRC_W_W),
      .IDX_W    (X_W)
   ) u_map_x (
      .is_read  (is_read),
      .pos      (a_col_ff),
      .pad      (pad_l_ff),
      .size_reg (src_w_ff),
      .mode     (mode_ff),
      .idx      (x_idx),
      .ok       (x_ok)
   );

   tbp_axis_map #(
      .MAX_SIZE (MAX_HEIGHT),
      .POS_W    (tbp_pkg::ROW_W),
      .PAD_W    (tbp_pkg::PAD_T_W),
      .SZ_W     (tbp_pkg::SRC_H_W),
      .IDX_W    (Y_W)
   ) u_map_y (
      .is_read  (is_read),
      .pos      (a_row_ff),
      .pad      (pad_t_ff),
      .size_reg (src_h_ff),
      .mode     (mode_ff),
      .idx      (y_idx),
      .ok       (y_ok)
   );

   tbp_axis_map #(
      .MAX_SIZE (MAX_CHANNELS),
      .POS_W    (tbp_pkg::CHAN_W),
      .PAD_W    (tbp_pkg::PAD_F_W),
      .SZ_W     (tbp_pkg::SRC_C_W),
      .IDX_W    (Z_W)
   ) u_map_z (
      .is_read  (is_read),
      .pos      (a_chan_ff),
      .pad      (pad_f_ff),
      .size_reg (src_c_ff),
      .mode     (mode_ff),
      .idx      (z_idx),
      .ok       (z_ok)
   );

   assign all_ok = x_ok && y_ok && z_ok;
   assign addr   = ADDR_W'(z_idx) * ADDR_W'(PLANE)
                 + ADDR_W'(y_idx) * ADDR_W'(MAX_WIDTH)
                 + ADDR_W'(x_idx);

   // element memory
   logic                 mem_wr, mem_rd;
   logic [ELEM_BITS-1:0] mem_q;

   assign mem_wr = a_valid_ff && !is_read && all_ok;
   assign mem_rd = a_valid_ff && is_read && all_ok;

   tbp_elem_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (ELEM_BITS)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr),
      .rd_en  (mem_rd),
      .addr   (addr),
      .wdata  (a_wdata_ff),
      .rdata  (mem_q)
   );

   // response
   logic b_valid_ff, b_valid_in;
   logic b_fill_ff;

   assign b_valid_in = a_valid_ff && is_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         b_fill_ff <= !all_ok;
      end
   end

   assign rsp_valid     = b_valid_ff;
   assign rsp_from_fill = b_fill_ff;
   assign rsp_rdata     = tbp_pkg::WORD_W'(b_fill_ff ? fill_ff : mem_q);

endmodule

FILE: tb/sv/tbp_checker.sv
// tbp_checker: predicts and checks the results of tensor_border_padding_top.
// Watches the request, result and csr ports and counts mismatches; uses tbp_pkg.
module tbp_checker
   import tbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_operation,
   input  logic [COL_W-1:0]      req_col,
   input  logic [ROW_W-1:0]      req_row,
   input  logic [CHAN_W-1:0]     req_chan,
   input  logic [WORD_W-1:0]     req_wdata,
   input  logic                  rsp_valid,
   input  logic [WORD_W-1:0]     rsp_rdata,
   input  logic                  rsp_from_fill,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  run_done,
   output int                    fail_count,
   output int                    pending
);

   localparam int MAX_W = 64;
   localparam int MAX_H = 64;
   localparam int MAX_C = 4;

   typedef struct packed {
      logic [WORD_W-1:0] rdata;
      logic              from_fill;
   } padded_elem_type;

   logic [WORD_W-1:0]  elem_store [MAX_W*MAX_H*MAX_C];
   logic [SRC_W_W-1:0] src_w;
   logic [SRC_H_W-1:0] src_h;
   logic [SRC_C_W-1:0] src_c;
   logic [PAD_T_W-1:0] pad_t;
   logic [PAD_L_W-1:0] pad_l;
   logic [PAD_F_W-1:0] pad_f;
   pad_mode_type       mode;
   logic [WORD_W-1:0]  fill;
   padded_elem_type    padded_q[$];
   int                 mismatches = 0;
   bit                 leftover_seen = 0;

   function automatic int clamp_size(int v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // returns 0 when constant (or unused-mode) padding lands outside the source
   function automatic bit map_axis(int pos, int size, pad_mode_type m, output int idx);
      int p;
      p = pos;
      idx = 0;
      case (m)
         PAD_REPLICATE: begin
            if (p < 0) p = 0;
            if (p > size - 1) p = size - 1;
         end
         PAD_REFLECT: begin
            if (p < 0) begin
               p = -p;
               if (p > size - 1) p = size - 1;
            end else if (p > size - 1) begin
               p = 2 * (size - 1) - p;
               if (p < 0) p = 0;
            end
         end
         default: begin
            if (p < 0 || p >= size) return 1'b0;
         end
      endcase
      idx = p;
      return 1'b1;
   endfunction

   function automatic int store_addr(int x, int y, int z);
      return (z * MAX_H + y) * MAX_W + x;
   endfunction

   always @(posedge clock) begin : watch
      padded_elem_type want;
      int w, h, c, x, y, z;
      if (reset) begin
         src_w = SRC_W_RST;
         src_h = SRC_H_RST;
         src_c = SRC_C_RST;
         pad_t = '0;
         pad_l = '0;
         pad_f = '0;
         mode  = PAD_CONST;
         fill  = '0;
         padded_q.delete();
      end else begin
         w = clamp_size(int'(src_w), MAX_W);
         h = clamp_size(int'(src_h), MAX_H);
         c = clamp_size(int'(src_c), MAX_C);
         if (rsp_valid) begin
            if (padded_q.size() == 0) begin
               $error("result with no transaction waiting: rdata %h from_fill %b",
                      rsp_rdata, rsp_from_fill);
               mismatches++;
            end else begin
               want = padded_q.pop_front();
               if (rsp_rdata !== want.rdata) begin
                  $error("rdata: expected %h, actual %h", want.rdata, rsp_rdata);
                  mismatches++;
               end
               if (rsp_from_fill !== want.from_fill) begin
                  $error("from_fill: expected %b, actual %b", want.from_fill, rsp_from_fill);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            if (req_operation == OP_WRITE) begin
               if (int'(req_col) < w && int'(req_row) < h && int'(req_chan) < c)
                  elem_store[store_addr(int'(req_col), int'(req_row), int'(req_chan))] = req_wdata;
            end else begin
               if (map_axis(int'(req_col) - int'(pad_l), w, mode, x) &&
                   map_axis(int'(req_row) - int'(pad_t), h, mode, y) &&
                   map_axis(int'(req_chan) - int'(pad_f), c, mode, z))
                  want = '{rdata: elem_store[store_addr(x, y, z)], from_fill: 1'b0};
               else
                  want = '{rdata: fill, from_fill: 1'b1};
               padded_q.push_back(want);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:    src_w = csr_wdata[SRC_W_W-1:0];
               CSR_SRC_HEIGHT:   src_h = csr_wdata[SRC_H_W-1:0];
               CSR_SRC_CHANNELS: src_c = csr_wdata[SRC_C_W-1:0];
               CSR_PAD_TOP:      pad_t = csr_wdata[PAD_T_W-1:0];
               CSR_PAD_LEFT:     pad_l = csr_wdata[PAD_L_W-1:0];
               CSR_PAD_FRONT:    pad_f = csr_wdata[PAD_F_W-1:0];
               CSR_PAD_MODE:     mode  = pad_mode_type'(csr_wdata[MODE_W-1:0]);
               CSR_FILL_WORD:    fill  = csr_wdata[WORD_W-1:0];
               default: ;
            endcase
         end
         if (run_done && !leftover_seen && padded_q.size() != 0) begin
            $error("%0d read transactions never answered", padded_q.size());
            mismatches += padded_q.size();
            leftover_seen = 1'b1;
         end
      end
      fail_count <= mismatches;
      pending    <= padded_q.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for tensor_border_padding_top.
// Drives directed and random write/read transactions over many pad settings;
// tbp_checker does the prediction. Uses tbp_pkg.
module tb_top;
   import tbp_pkg::*;

   localparam int MAX_W           = 64;
   localparam int MAX_H           = 64;
   localparam int MAX_C           = 4;
   localparam int IDLE_LIMIT      = 200;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 55;

   typedef struct {
      logic [SRC_W_W-1:0] w;
      logic [SRC_H_W-1:0] h;
      logic [SRC_C_W-1:0] c;
      logic [PAD_T_W-1:0] pt;
      logic [PAD_L_W-1:0] pl;
      logic [PAD_F_W-1:0] pf;
      pad_mode_type       mode;
      logic [WORD_W-1:0]  fill;
   } pad_setting_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_operation = 1'b0;
   logic [COL_W-1:0]      req_col = '0;
   logic [ROW_W-1:0]      req_row = '0;
   logic [CHAN_W-1:0]     req_chan = '0;
   logic [WORD_W-1:0]     req_wdata = '0;
   logic                  rsp_valid;
   logic [WORD_W-1:0]     rsp_rdata;
   logic                  rsp_from_fill;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  run_done = 1'b0;
   int                    fail_count;
   int                    pending;

   pad_setting_type cfg;
   int              cw = MAX_W;
   int              ch = MAX_H;
   int              cc = MAX_C;
   bit              written [MAX_W*MAX_H*MAX_C];
   bit              idle_on = 1'b1;
   int              items = 0;
   int              idle_cycles = 0;

   always #5 clock = ~clock;

   tensor_border_padding_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_chan      (req_chan),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_rdata     (rsp_rdata),
      .rsp_from_fill (rsp_from_fill),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   tbp_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_chan      (req_chan),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_rdata     (rsp_rdata),
      .rsp_from_fill (rsp_from_fill),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .run_done      (run_done),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int eff_size(int v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // source index a read lands on, so that no unwritten element is ever read
   function automatic bit source_of(int pos, int size, pad_mode_type m, output int idx);
      idx = pos;
      if (m == PAD_REPLICATE || m == PAD_REFLECT) begin
         if (idx < 0) idx = (m == PAD_REFLECT) ? -idx : 0;
         else if (idx > size - 1) idx = (m == PAD_REFLECT) ? 2 * (size - 1) - idx : size - 1;
         if (idx < 0) idx = 0;
         if (idx > size - 1) idx = size - 1;
         return 1'b1;
      end
      return idx >= 0 && idx < size;
   endfunction

   function automatic int pick_coord(int pad, int size, int maxv);
      int edges [6];
      int near_hi;
      int v;
      edges = '{0, pad - 1, pad, pad + size - 1, pad + size, maxv};
      near_hi = pad + size + 4;
      if (near_hi > maxv) near_hi = maxv;
      case ($urandom_range(0, 3))
         0: v = edges[$urandom_range(0, 5)];
         1: v = $urandom_range(0, maxv);
         default: v = $urandom_range(0, near_hi);
      endcase
      if (v < 0) v = 0;
      if (v > maxv) v = maxv;
      return v;
   endfunction

   function automatic pad_setting_type setting_for(int ph);
      pad_setting_type s;
      s.w    = ($urandom_range(0, 3) == 0) ? SRC_W_W'($urandom_range(0, 127))
                                           : SRC_W_W'($urandom_range(1, 8));
      s.h    = ($urandom_range(0, 3) == 0) ? SRC_H_W'($urandom_range(0, 127))
                                           : SRC_H_W'($urandom_range(1, 8));
      s.c    = SRC_C_W'($urandom_range(0, 7));
      s.pt   = PAD_T_W'($urandom_range(0, 63));
      s.pl   = PAD_L_W'($urandom_range(0, 63));
      s.pf   = PAD_F_W'($urandom_range(0, 3));
      s.mode = pad_mode_type'($urandom_range(0, 3));
      s.fill = $urandom();
      case (ph)
         0: s = '{w: 1, h: 1, c: 1, pt: 63, pl: 63, pf: 3, mode: PAD_REFLECT, fill: '1};
         1: s = '{w: 64, h: 64, c: 4, pt: 0, pl: 0, pf: 0, mode: PAD_REPLICATE, fill: '0};
         2: s = '{w: 0, h: 127, c: 7, pt: 5, pl: 0, pf: 1, mode: PAD_UNUSED,
                  fill: 32'hA5C3_0F96};
         3: begin
            s = '{w: 64, h: 64, c: 4, pt: 63, pl: 63, pf: 3, mode: PAD_REFLECT, fill: '0};
            s.fill = $urandom();
         end
         4: s = '{w: 2, h: 3, c: 2, pt: 1, pl: 2, pf: 3, mode: PAD_CONST, fill: 32'h0000_0001};
         default: ;
      endcase
      return s;
   endfunction

   task automatic send(op_type op, int col, int row, int chan, logic [WORD_W-1:0] data);
      int gap;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_col       <= COL_W'(col);
      req_row       <= ROW_W'(row);
      req_chan      <= CHAN_W'(chan);
      req_wdata     <= data;
      do @(posedge clock); while (busy);
   endtask

   task automatic store(int col, int row, int chan, logic [WORD_W-1:0] data);
      send(OP_WRITE, col, row, chan, data);
      if (col < cw && row < ch && chan < cc) begin
         written[(chan * MAX_H + row) * MAX_W + col] = 1'b1;
         items++;
      end
   endtask

   task automatic read_at(int col, int row, int chan);
      int x, y, z;
      if (source_of(col - int'(cfg.pl), cw, cfg.mode, x) &&
          source_of(row - int'(cfg.pt), ch, cfg.mode, y) &&
          source_of(chan - int'(cfg.pf), cc, cfg.mode, z)) begin
         if (!written[(z * MAX_H + y) * MAX_W + x]) store(x, y, z, $urandom());
      end
      send(OP_READ, col, row, chan, $urandom());
      items++;
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      // a write may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(pad_setting_type s);
      wait_quiet();
      cfg = s;
      cw = eff_size(int'(s.w), MAX_W);
      ch = eff_size(int'(s.h), MAX_H);
      cc = eff_size(int'(s.c), MAX_C);
      csr_we    <= 1'b1;
      csr_index <= CSR_SRC_WIDTH;
      csr_wdata <= CSR_DATA_W'(s.w);
      @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT;
      csr_wdata <= CSR_DATA_W'(s.h);
      @(posedge clock);
      csr_index <= CSR_SRC_CHANNELS;
      csr_wdata <= CSR_DATA_W'(s.c);
      @(posedge clock);
      csr_index <= CSR_PAD_TOP;
      csr_wdata <= CSR_DATA_W'(s.pt);
      @(posedge clock);
      csr_index <= CSR_PAD_LEFT;
      csr_wdata <= CSR_DATA_W'(s.pl);
      @(posedge clock);
      csr_index <= CSR_PAD_FRONT;
      csr_wdata <= CSR_DATA_W'(s.pf);
      @(posedge clock);
      csr_index <= CSR_PAD_MODE;
      csr_wdata <= CSR_DATA_W'(s.mode);
      @(posedge clock);
      csr_index <= CSR_FILL_WORD;
      csr_wdata <= s.fill;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      cfg = '{w: SRC_W_RST, h: SRC_H_RST, c: SRC_C_RST, pt: 0, pl: 0, pf: 0,
              mode: PAD_CONST, fill: '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: corners, writes outside the source, reads outside it
      store(0, 0, 0, '1);
      store(63, 63, 3, '0);
      store(63, 0, 0, 32'h8000_0001);
      store(255, 255, 15, '1);
      store(64, 0, 0, 32'h1234_5678);
      store(0, 64, 0, 32'h1234_5678);
      store(0, 0, 4, 32'h1234_5678);
      read_at(0, 0, 0);
      read_at(63, 63, 3);
      read_at(63, 0, 0);
      read_at(255, 255, 15);
      read_at(64, 0, 0);
      read_at(0, 64, 0);
      read_at(0, 0, 4);

      for (int ph = 0; ph < PHASES; ph++) begin
         apply_setting(setting_for(ph));
         idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 4) < 3)
               read_at(pick_coord(int'(cfg.pl), cw, 255), pick_coord(int'(cfg.pt), ch, 255),
                       pick_coord(int'(cfg.pf), cc, 15));
            else if ($urandom_range(0, 7) == 0)
               store($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom());
            else
               store($urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                     $urandom_range(0, cc - 1), $urandom());
         end
      end

      wait_quiet();
      repeat (4) @(posedge clock);
      run_done <= 1'b1;
      repeat (3) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
